// ===== src/svsm_pkg.sv =====
// ----------------------------------------------------------------------------
// svsm_pkg: shared types and constants
// Widths, request codes and the control struct between the sequencer and
// the modular arithmetic unit.
// ----------------------------------------------------------------------------
package svsm_pkg;
    localparam int MAX_ENTRIES = 32;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int PTR_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int IDX_W       = 32;
    localparam int VAL_W       = 64;

    localparam logic [1:0] REQ_LOAD_U = 2'd0;
    localparam logic [1:0] REQ_LOAD_V = 2'd1;
    localparam logic [1:0] REQ_MERGE  = 2'd2;

    localparam logic [0:0] ADDR_MODULUS = 1'b0;
    localparam logic [0:0] ADDR_SCALE   = 1'b1;

    // op codes for the shared arithmetic unit
    localparam logic [1:0] OP_MOD = 2'd0; // a mod n
    localparam logic [1:0] OP_MUL = 2'd1; // a*b mod n, a,b < n
    localparam logic [1:0] OP_SUB = 2'd2; // a-b mod n, a,b < n

    typedef struct packed {
        logic             start;
        logic [1:0]       op;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] res;
    } t_alu_rsp;
endpackage

// ===== src/svsm_alu.sv =====
// ----------------------------------------------------------------------------
// svsm_alu: bit-serial modular arithmetic unit
// Reduction by restoring shift-subtract and multiply by double-and-add, one
// bit per cycle, and a single-step subtract.
// ----------------------------------------------------------------------------
module svsm_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [63:0]          i_n,
    input  svsm_pkg::t_alu_req   i_req,
    output svsm_pkg::t_alu_rsp   o_rsp
);
    import svsm_pkg::*;

    logic             r_busy, n_busy;
    logic [1:0]       r_op, n_op;
    logic [6:0]       r_bit, n_bit;
    logic [VAL_W-1:0] r_acc, n_acc;
    logic [VAL_W-1:0] r_a, n_a;
    logic [VAL_W-1:0] r_b, n_b;
    logic             r_done, n_done;

    logic [VAL_W:0]   dbl;
    logic [VAL_W-1:0] dbl_m;
    logic [VAL_W:0]   sum;
    logic [VAL_W-1:0] sum_m;

    always_comb begin
        // one doubling and one conditional add per cycle
        dbl   = {r_acc, 1'b0};
        if (r_op == OP_MOD) dbl = {r_acc, r_a[VAL_W-1]};
        dbl_m = (dbl >= {1'b0, i_n}) ? VAL_W'(dbl - {1'b0, i_n}) : dbl[VAL_W-1:0];
        sum   = {1'b0, dbl_m} + {1'b0, r_b};
        sum_m = (sum >= {1'b0, i_n}) ? VAL_W'(sum - {1'b0, i_n}) : sum[VAL_W-1:0];
    end

    always_comb begin
        n_busy = r_busy;
        n_op   = r_op;
        n_bit  = r_bit;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_done = 1'b0;
        if (!r_busy && i_req.start) begin
            n_op = i_req.op;
            n_a  = i_req.a;
            n_b  = i_req.b;
            n_acc = '0;
            if (i_req.op == OP_SUB) begin
                n_acc  = (i_req.a >= i_req.b) ? i_req.a - i_req.b
                                              : i_req.a - i_req.b + i_n;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_bit  = 7'd64;
            end
        end else if (r_busy) begin
            if (r_op == OP_MOD) begin
                n_acc = dbl_m;
                n_a   = {r_a[VAL_W-2:0], 1'b0};
            end else begin
                n_acc = r_a[VAL_W-1] ? sum_m : dbl_m;
                n_a   = {r_a[VAL_W-2:0], 1'b0};
            end
            n_bit = r_bit - 7'd1;
            if (r_bit == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MOD;
            r_bit  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_bit  <= n_bit;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_acc;
endmodule

// ===== src/sparse_vec_submul_mod_n.sv =====
// ----------------------------------------------------------------------------
// sparse_vec_submul_mod_n: sparse w = u - c*v modulo n
// Loads entries of u and v, then merges them by index through one shared
// bit-serial modular unit.
// ----------------------------------------------------------------------------
// A load leaves busy low; a merge holds busy while it reduces scale, then takes each
// entry of u alone, of v alone or of a shared index through the 64-step serial unit,
// and closes; the final result strobes as busy drops.
// Results come out one per strobe; the receiver cannot stall them.
// Reset (synchronous, active low) clears counts, overflow and configuration
// (modulus 1, scale 0); store contents are not cleared.
module sparse_vec_submul_mod_n (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_entry_index,
    input  logic [63:0] i_entry_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic        o_strobe,
    output logic [31:0] o_out_index,
    output logic [63:0] o_out_value,
    output logic        o_is_last,
    output logic        o_empty_result,
    output logic        o_overflow
);
    import svsm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CRED  = 4'd1;
    localparam logic [3:0] S_CWAIT = 4'd2;
    localparam logic [3:0] S_PICK  = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_DEC   = 4'd5;
    localparam logic [3:0] S_RU    = 4'd6;
    localparam logic [3:0] S_RV    = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_SUB   = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    // stores: memories with registered reads
    logic [IDX_W-1:0] u_idx_mem [MAX_ENTRIES];
    logic [VAL_W-1:0] u_val_mem [MAX_ENTRIES];
    logic [IDX_W-1:0] v_idx_mem [MAX_ENTRIES];
    logic [VAL_W-1:0] v_val_mem [MAX_ENTRIES];
    logic [IDX_W-1:0] r_ui, r_vi;
    logic [VAL_W-1:0] r_uv, r_vv;

    logic [63:0]      r_modulus, r_scale;
    logic [CNT_W-1:0] r_ucnt, r_vcnt, r_i, n_i, r_j, n_j;
    logic             r_ovf;
    logic [3:0]       r_state, n_state;
    logic [VAL_W-1:0] r_c, n_c, r_negc, n_negc, r_tu, n_tu, r_tv, n_tv;
    logic [1:0]       r_kind, n_kind; // 0 u only, 1 v only, 2 both
    logic             r_pend, n_pend; // an entry is held for emission
    logic [IDX_W-1:0] r_pidx, n_pidx;
    logic [VAL_W-1:0] r_pval, n_pval;
    logic             r_str, n_str, r_last, n_last, r_emp, n_emp;
    logic [VAL_W-1:0] r_oval, n_oval;
    logic             r_aflag, n_aflag; // alu request issued this state

    logic [63:0] n_eff;
    t_alu_req    alu_req;
    t_alu_rsp    alu_rsp;
    logic        accept, cfg_wr, has_u, has_v, cz;

    assign n_eff  = (r_modulus == 64'd0) ? 64'd1 : r_modulus;
    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[3] ? r_scale : r_modulus;
    assign has_u  = r_i < r_ucnt;
    assign has_v  = r_j < r_vcnt;
    assign cz     = (r_c == 64'd0);

    svsm_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_n     (n_eff),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    // load writes and registered reads at the merge heads
    always_ff @(posedge i_clk) begin
        if (accept && i_req_type == REQ_LOAD_U && r_ucnt < CNT_W'(MAX_ENTRIES)) begin
            u_idx_mem[r_ucnt[PTR_W-1:0]] <= i_entry_index;
            u_val_mem[r_ucnt[PTR_W-1:0]] <= i_entry_value;
        end
        if (accept && i_req_type == REQ_LOAD_V && r_vcnt < CNT_W'(MAX_ENTRIES)) begin
            v_idx_mem[r_vcnt[PTR_W-1:0]] <= i_entry_index;
            v_val_mem[r_vcnt[PTR_W-1:0]] <= i_entry_value;
        end
        r_ui <= u_idx_mem[r_i[PTR_W-1:0]];
        r_uv <= u_val_mem[r_i[PTR_W-1:0]];
        r_vi <= v_idx_mem[r_j[PTR_W-1:0]];
        r_vv <= v_val_mem[r_j[PTR_W-1:0]];
    end

    always_comb begin
        n_state = r_state;
        n_i = r_i;   n_j = r_j;
        n_c = r_c;   n_negc = r_negc;
        n_tu = r_tu; n_tv = r_tv;
        n_kind = r_kind;
        n_pend = r_pend; n_pidx = r_pidx; n_pval = r_pval;
        n_str = 1'b0; n_last = 1'b0; n_emp = 1'b0;
        n_oval = r_oval;
        n_aflag = 1'b0;
        alu_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_req_type == REQ_MERGE) begin
                    n_state = S_CRED;
                    n_i = '0; n_j = '0; n_pend = 1'b0;
                end
            end
            S_CRED: begin
                alu_req = '{start: 1'b1, op: OP_MOD, a: r_scale, b: '0};
                n_state = S_CWAIT;
            end
            S_CWAIT: begin
                if (alu_rsp.done) begin
                    n_c    = alu_rsp.res;
                    n_negc = (alu_rsp.res == 64'd0) ? 64'd0 : n_eff - alu_rsp.res;
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                // flush a held entry once the next is known or walk ends
                if (!has_u && (cz || !has_v)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_DEC; // read latency of the stores
            S_DEC: begin
                if (has_u && (cz || !has_v || r_ui < r_vi)) begin
                    n_kind = 2'd0; n_pidx = r_ui; n_i = r_i + 1'b1;
                end else if (has_v && (!has_u || r_vi < r_ui)) begin
                    n_kind = 2'd1; n_pidx = r_vi; n_j = r_j + 1'b1;
                end else begin
                    n_kind = 2'd2; n_pidx = r_ui;
                    n_i = r_i + 1'b1; n_j = r_j + 1'b1;
                end
                n_tu = r_uv; n_tv = r_vv;
                n_state = (n_kind == 2'd1) ? S_RV : S_RU;
                n_aflag = 1'b1;
            end
            S_RU: begin
                if (r_aflag) alu_req = '{start: 1'b1, op: OP_MOD, a: r_tu, b: '0};
                if (alu_rsp.done) begin
                    n_tu = alu_rsp.res;
                    n_aflag = 1'b1;
                    n_state = (r_kind == 2'd0) ? S_EMIT : S_RV;
                end
            end
            S_RV: begin
                if (r_aflag) alu_req = '{start: 1'b1, op: OP_MOD, a: r_tv, b: '0};
                if (alu_rsp.done) begin
                    n_tv = alu_rsp.res;
                    n_aflag = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_aflag) alu_req = '{start: 1'b1, op: OP_MUL, a: r_tv,
                                         b: (r_kind == 2'd1) ? r_negc : r_c};
                if (alu_rsp.done) begin
                    n_tv = alu_rsp.res;
                    n_aflag = 1'b1;
                    n_state = (r_kind == 2'd1) ? S_EMIT : S_SUB;
                end
            end
            S_SUB: begin
                if (r_aflag) alu_req = '{start: 1'b1, op: OP_SUB, a: r_tu, b: r_tv};
                if (alu_rsp.done) begin
                    n_tu = alu_rsp.res;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold the new entry unless a shared index cancels to zero; the previous one goes out not last
                n_tu = (r_kind == 2'd1) ? r_tv : r_tu;
                if (r_kind != 2'd2 || n_tu != 64'd0) begin
                    if (r_pend) begin
                        n_str = 1'b1; n_oval = r_pval;
                    end
                    n_pend = 1'b1; n_pval = n_tu;
                end
                n_state = S_PICK;
            end
            S_FIN: begin
                n_str = 1'b1; n_last = 1'b1;
                n_emp = !r_pend;
                n_oval = r_pend ? r_pval : 64'd0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output index register tracks the held entry separately from the port
    logic [IDX_W-1:0] r_hidx;
    logic [IDX_W-1:0] r_pidx_q;
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && (r_kind != 2'd2 || n_tu != 64'd0)) begin
            r_hidx <= r_pidx;
        end
        r_pidx_q <= r_hidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_modulus <= 64'd1;
            r_scale <= 64'd0;
            r_ucnt <= '0; r_vcnt <= '0; r_ovf <= 1'b0;
            r_str <= 1'b0; r_pend <= 1'b0; r_aflag <= 1'b0;
        end else begin
            r_state <= n_state;
            r_str <= n_str;
            r_pend <= n_pend;
            r_aflag <= n_aflag;
            if (cfg_wr && paddr[3] == ADDR_MODULUS) r_modulus <= pwdata;
            if (cfg_wr && paddr[3] == ADDR_SCALE)   r_scale <= pwdata;
            if (accept && i_req_type == REQ_LOAD_U) begin
                if (r_ucnt < CNT_W'(MAX_ENTRIES)) r_ucnt <= r_ucnt + 1'b1;
                else r_ovf <= 1'b1;
            end
            if (accept && i_req_type == REQ_LOAD_V) begin
                if (r_vcnt < CNT_W'(MAX_ENTRIES)) r_vcnt <= r_vcnt + 1'b1;
                else r_ovf <= 1'b1;
            end
            if (r_state == S_FIN) begin
                r_ucnt <= '0; r_vcnt <= '0; r_ovf <= 1'b0;
            end
        end
        r_i <= n_i; r_j <= n_j;
        r_c <= n_c; r_negc <= n_negc;
        r_tu <= n_tu; r_tv <= n_tv;
        r_kind <= n_kind;
        r_pidx <= n_pidx; r_pval <= n_pval;
        r_oval <= n_oval;
        r_last <= n_last; r_emp <= n_emp;
    end

    // overflow flag as it stood during the merge
    logic r_ovf_o;
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) r_ovf_o <= r_ovf;
    end

    assign o_strobe       = r_str;
    assign o_out_index    = r_emp ? 32'd0 : (r_last ? r_hidx : r_pidx_q);
    assign o_out_value    = r_oval;
    assign o_is_last      = r_last;
    assign o_empty_result = r_emp;
    assign o_overflow     = r_ovf_o;
endmodule
